// ===== hdl/lcg_random_draw_unit_core_macros.svh =====
// assertion macros for the lcg random draw unit
// used by the controller and datapath modules; no other dependencies
`ifndef LCG_RANDOM_DRAW_UNIT_CORE_MACROS_SVH
`define LCG_RANDOM_DRAW_UNIT_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define LCGRDU_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lcgrdu same-cycle check failed");
// next-cycle implication
`define LCGRDU_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lcgrdu next-cycle check failed");
`else
`define LCGRDU_ASSERT_IMP(label, clk, rst, ante, cons)
`define LCGRDU_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/lcgrdu_pkg.sv =====
// shared constants, request codes and command types for the lcg random draw unit
// no dependencies
`timescale 1ns / 1ps

package lcgrdu_pkg;

  localparam int FRACTION_BITS_DEF = 23;

  // request kinds
  localparam logic [2:0] REQ_RAW   = 3'd0;
  localparam logic [2:0] REQ_RANGE = 3'd1;
  localparam logic [2:0] REQ_BIT   = 3'd2;
  localparam logic [2:0] REQ_FRAC  = 3'd3;
  localparam logic [2:0] REQ_LOAD  = 3'd4;

  // generator constants
  localparam logic [30:0] LCG_MOD    = 31'd2147395600;  // 46340 squared
  localparam logic [30:0] LCG_HALF   = 31'd1073697800;
  localparam logic [15:0] LCG_ROOT   = 16'd46340;
  localparam logic [24:0] LCG_MUL    = 25'd31415821;
  // 2^31 mod LCG_MOD, used to fold the high part of a product
  localparam logic [16:0] FOLD_C     = 17'd88048;
  // floor(2^32 / 46340), reciprocal for the divide by the root
  localparam logic [16:0] ROOT_RECIP = 17'd92683;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_MUL,
    OP_FOLD1,
    OP_FOLD2,
    OP_FIN,
    OP_DIVA,
    OP_DIVB,
    OP_DIVC,
    OP_HMUL
  } op_t;

  // command from controller to datapath
  typedef struct packed {
    logic       start;   // input beat accepted this cycle
    op_t        op;
    logic [2:0] kind;    // request kind of the item in work
    logic       second;  // second pass of the range divide
  } cmd_t;

endpackage

// ===== hdl/lcgrdu_ctrl.sv =====
// controller state machine for the lcg random draw unit
// depends on lcgrdu_pkg and lcg_random_draw_unit_core_macros.svh
`timescale 1ns / 1ps
`include "lcg_random_draw_unit_core_macros.svh"

module lcgrdu_ctrl #(
  parameter int FRACTION_BITS = lcgrdu_pkg::FRACTION_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [2:0]        req_type,
  input  logic              out_free,
  output logic              in_ready,
  output logic              done,
  output lcgrdu_pkg::cmd_t  cmd
);

  localparam int CW = (FRACTION_BITS > 1) ? $clog2(FRACTION_BITS) : 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_FOLD1,
    S_FOLD2,
    S_FIN,
    S_DIVA,
    S_DIVB,
    S_DIVC,
    S_HMUL,
    S_POST
  } state_t;

  state_t          state;
  logic [2:0]      kind;
  logic [CW-1:0]   cnt;
  logic            second;
  logic            frac_more;

  // handshake status
  assign in_ready = (state == S_IDLE);
  assign done     = (state == S_POST) && out_free;

  // another fraction bit still to draw
  assign frac_more = (state == S_FIN) && (kind == lcgrdu_pkg::REQ_FRAC) && (cnt != '0);

  // command decode
  always_comb begin
    cmd.start  = (state == S_IDLE) && in_valid;
    cmd.kind   = (state == S_IDLE) ? req_type : kind;
    cmd.second = second;
    case (state)
      S_MUL:   cmd.op = lcgrdu_pkg::OP_MUL;
      S_FOLD1: cmd.op = lcgrdu_pkg::OP_FOLD1;
      S_FOLD2: cmd.op = lcgrdu_pkg::OP_FOLD2;
      S_FIN:   cmd.op = lcgrdu_pkg::OP_FIN;
      S_DIVA:  cmd.op = lcgrdu_pkg::OP_DIVA;
      S_DIVB:  cmd.op = lcgrdu_pkg::OP_DIVB;
      S_DIVC:  cmd.op = lcgrdu_pkg::OP_DIVC;
      S_HMUL:  cmd.op = lcgrdu_pkg::OP_HMUL;
      default: cmd.op = lcgrdu_pkg::OP_NONE;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      kind   <= lcgrdu_pkg::REQ_RAW;
      cnt    <= '0;
      second <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            kind   <= req_type;
            second <= 1'b0;
            cnt    <= (req_type == lcgrdu_pkg::REQ_FRAC) ? CW'(FRACTION_BITS - 1) : '0;
            if (req_type inside {lcgrdu_pkg::REQ_RAW, lcgrdu_pkg::REQ_RANGE,
                                 lcgrdu_pkg::REQ_BIT, lcgrdu_pkg::REQ_FRAC}) begin
              state <= S_MUL;
            end else begin
              state <= S_POST;
            end
          end
        end
        S_MUL:   state <= S_FOLD1;
        S_FOLD1: state <= S_FOLD2;
        S_FOLD2: state <= S_FIN;
        S_FIN: begin
          if (kind == lcgrdu_pkg::REQ_RANGE) begin
            state <= S_DIVA;
          end else if (frac_more) begin
            cnt   <= cnt - CW'(1);
            state <= S_MUL;
          end else begin
            state <= S_POST;
          end
        end
        S_DIVA: state <= S_DIVB;
        S_DIVB: state <= S_DIVC;
        S_DIVC: state <= second ? S_POST : S_HMUL;
        S_HMUL: begin
          second <= 1'b1;
          state  <= S_DIVA;
        end
        S_POST: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `LCGRDU_ASSERT_NXT(a_frac_loops, clk, rst, frac_more, state == S_MUL)
  `LCGRDU_ASSERT_NXT(a_done_idle, clk, rst, done, state == S_IDLE)
  `LCGRDU_ASSERT_NXT(a_start_busy, clk, rst, cmd.start, state != S_IDLE)
  `LCGRDU_ASSERT_IMP(a_second_range, clk, rst, second, kind == lcgrdu_pkg::REQ_RANGE)

endmodule

// ===== hdl/lcgrdu_dp.sv =====
// datapath for the lcg random draw unit: seed, modular multiply, divide by root
// depends on lcgrdu_pkg and lcg_random_draw_unit_core_macros.svh
`timescale 1ns / 1ps
`include "lcg_random_draw_unit_core_macros.svh"

module lcgrdu_dp #(
  parameter int FRACTION_BITS = lcgrdu_pkg::FRACTION_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  lcgrdu_pkg::cmd_t  cmd,
  input  logic [15:0]       range_n,
  input  logic [31:0]       seed_value,
  output logic [30:0]       draw,
  output logic [31:0]       seed
);

  logic [56:0] prod;
  logic [43:0] v1;
  logic [31:0] v2;
  logic [48:0] dprod;
  logic [16:0] qest;
  logic [32:0] qd;
  logic [15:0] qhi;
  logic [31:0] hn;
  logic [15:0] n_reg;

  logic [31:0] v2_sub;
  logic [30:0] red;
  logic [30:0] seed_adv;
  logic        draw_bit;
  logic [31:0] div_x;
  logic [32:0] rem;
  logic [16:0] q;
  logic        rem_ok;

  // final reduce of the folded product and the plus one step
  always_comb begin
    v2_sub   = v2 - {1'b0, lcgrdu_pkg::LCG_MOD};
    red      = (v2 >= {1'b0, lcgrdu_pkg::LCG_MOD}) ? v2_sub[30:0] : v2[30:0];
    seed_adv = (red == lcgrdu_pkg::LCG_MOD - 31'd1) ? '0 : red + 31'd1;
    draw_bit = (seed_adv < lcgrdu_pkg::LCG_HALF);
  end

  // divide by root: estimate correction
  always_comb begin
    div_x  = cmd.second ? hn : seed;
    rem    = {1'b0, div_x} - qd;
    q      = (rem >= 33'(lcgrdu_pkg::LCG_ROOT)) ? qest + 17'd1 : qest;
    rem_ok = (rem < (33'(lcgrdu_pkg::LCG_ROOT) << 1));
  end

  // seed register
  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (cmd.start && cmd.kind == lcgrdu_pkg::REQ_LOAD) begin
      seed <= seed_value;
    end else if (cmd.op == lcgrdu_pkg::OP_FIN) begin
      seed <= {1'b0, seed_adv};
    end
  end

  // arithmetic pipeline and draw accumulation
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      draw  <= '0;
      n_reg <= range_n;
    end
    case (cmd.op)
      lcgrdu_pkg::OP_MUL:   prod <= 57'(seed) * 57'(lcgrdu_pkg::LCG_MUL);
      lcgrdu_pkg::OP_FOLD1: v1 <= 44'(prod[56:31]) * 44'(lcgrdu_pkg::FOLD_C) + 44'(prod[30:0]);
      lcgrdu_pkg::OP_FOLD2: v2 <= 32'(v1[43:31]) * 32'(lcgrdu_pkg::FOLD_C) + 32'(v1[30:0]);
      lcgrdu_pkg::OP_FIN: begin
        case (cmd.kind)
          lcgrdu_pkg::REQ_RAW: draw <= seed_adv;
          lcgrdu_pkg::REQ_BIT: draw <= {30'b0, draw_bit};
          lcgrdu_pkg::REQ_FRAC:
            draw <= (draw >> 1) | (31'(draw_bit) << (FRACTION_BITS - 1));
          default: draw <= draw;
        endcase
      end
      lcgrdu_pkg::OP_DIVA: dprod <= 49'(div_x) * 49'(lcgrdu_pkg::ROOT_RECIP);
      lcgrdu_pkg::OP_DIVB: begin
        qest <= dprod[48:32];
        qd   <= 33'(dprod[48:32]) * 33'(lcgrdu_pkg::LCG_ROOT);
      end
      lcgrdu_pkg::OP_DIVC: begin
        if (cmd.second) begin
          draw <= {14'b0, q};
        end else begin
          qhi <= q[15:0];
        end
      end
      lcgrdu_pkg::OP_HMUL: hn <= {16'b0, qhi} * {16'b0, n_reg};
      default: ;
    endcase
  end

  // checks
  `LCGRDU_ASSERT_NXT(a_seed_below_mod, clk, rst, cmd.op == lcgrdu_pkg::OP_FIN, seed < 32'(lcgrdu_pkg::LCG_MOD))
  `LCGRDU_ASSERT_IMP(a_div_one_fix, clk, rst, cmd.op == lcgrdu_pkg::OP_DIVC, rem_ok)
  `LCGRDU_ASSERT_NXT(a_range_bound, clk, rst, cmd.op == lcgrdu_pkg::OP_DIVC && cmd.second, draw <= 31'(n_reg))

endmodule

// ===== hdl/lcg_random_draw_unit_core.sv =====
// top level of the lcg random draw unit: handshake and output register
// depends on lcgrdu_pkg, lcgrdu_ctrl and lcgrdu_dp
`timescale 1ns / 1ps
//
// channel  handshake            payload
// -------  -------------------  ---------------------------------
// in       in_valid / in_ready  req_type, range_n, seed_value
// out      out_valid/out_ready  draw_value, seed_now
//
// each generator advance runs the modular multiply loop
// (multiply, two folds, final reduce); raw and bit draws run it once,
// range draws run it once and add two passes of the divide by 46340,
// fraction draws run it once per fraction bit; loads and unused kinds skip it
// reset clears the seed to zero, the controller and the output beat
// a new beat is taken while a finished result waits in the output register

module lcg_random_draw_unit_core #(
  parameter int FRACTION_BITS = lcgrdu_pkg::FRACTION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  req_type,
  input  logic [15:0] range_n,
  input  logic [31:0] seed_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [30:0] draw_value,
  output logic [31:0] seed_now
);

  lcgrdu_pkg::cmd_t cmd;
  logic             out_free;
  logic             done;
  logic [30:0]      dp_draw;
  logic [31:0]      dp_seed;

  assign out_free = !out_valid || out_ready;

  lcgrdu_ctrl #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .req_type (req_type),
    .out_free (out_free),
    .in_ready (in_ready),
    .done     (done),
    .cmd      (cmd)
  );

  lcgrdu_dp #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .range_n    (range_n),
    .seed_value (seed_value),
    .draw       (dp_draw),
    .seed       (dp_seed)
  );

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (done) begin
      draw_value <= dp_draw;
      seed_now   <= dp_seed;
    end
  end

endmodule

// ===== tb/tb_lcg_random_draw_unit_core.sv =====
// self-checking testbench for lcg_random_draw_unit_core: directed and random requests,
// predicted draws and seeds compared beat by beat; depends on lcgrdu_pkg and the core
`timescale 1ns / 1ps

module tb_lcg_random_draw_unit_core;

  localparam int FRAC_BITS      = lcgrdu_pkg::FRACTION_BITS_DEF;
  localparam int RANDOM_REQS    = 700;
  localparam int IDLE_PCT       = 10;
  localparam int QUIET_FIRST    = 250;   // accepted beats between these two see no idling
  localparam int QUIET_LAST     = 420;
  localparam int SETTLE_CYCLES  = 150;   // longer than one fraction draw
  localparam int WATCHDOG_LIMIT = 4000;

  // request kinds with no defined draw
  localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
  localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;

  typedef struct {
    logic [2:0]  kind;
    logic [15:0] n;
    logic [31:0] seed;
    bit          drain;   // hold back until every outstanding result is out
  } draw_req_t;

  typedef struct {
    logic [30:0] draw;
    logic [31:0] seed;
  } draw_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  req_type = '0;
  logic [15:0] range_n = '0;
  logic [31:0] seed_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [30:0] draw_value;
  logic [31:0] seed_now;

  draw_req_t    pending_reqs[$];
  draw_result_t expected_draws[$];
  logic [31:0]  lcg_seed = '0;
  int           results_due = 0;
  int           results_seen = 0;
  int           beats_in = 0;
  int           fail_count = 0;
  int           stuck_cycles = 0;
  logic         quiet;

  lcg_random_draw_unit_core #(
    .FRACTION_BITS(FRAC_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .range_n   (range_n),
    .seed_value(seed_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .draw_value(draw_value),
    .seed_now  (seed_now)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  assign quiet = (beats_in >= QUIET_FIRST) && (beats_in < QUIET_LAST);

  // one generator step on the predicted seed
  function automatic logic [31:0] lcg_advance();
    logic [63:0] prod;
    prod = (64'(lcg_seed) * 64'(lcgrdu_pkg::LCG_MUL)) % 64'(lcgrdu_pkg::LCG_MOD);
    lcg_seed = 32'((prod + 64'd1) % 64'(lcgrdu_pkg::LCG_MOD));
    return lcg_seed;
  endfunction

  // expected draw and seed for one accepted request
  function automatic draw_result_t predict_draw(input draw_req_t r);
    draw_result_t d;
    logic [63:0]  hi;
    int           i;
    d.draw = '0;
    case (r.kind)
      lcgrdu_pkg::REQ_RAW: d.draw = 31'(lcg_advance());
      lcgrdu_pkg::REQ_RANGE: begin
        hi = 64'(lcg_advance()) / 64'(lcgrdu_pkg::LCG_ROOT);
        d.draw = 31'((hi * 64'(r.n)) / 64'(lcgrdu_pkg::LCG_ROOT));
      end
      lcgrdu_pkg::REQ_BIT: d.draw[0] = lcg_advance() < 32'(lcgrdu_pkg::LCG_HALF);
      lcgrdu_pkg::REQ_FRAC: begin
        for (i = 0; i < FRAC_BITS; i++)
          d.draw[i] = lcg_advance() < 32'(lcgrdu_pkg::LCG_HALF);
      end
      lcgrdu_pkg::REQ_LOAD: lcg_seed = r.seed;
      default: ;
    endcase
    d.seed = lcg_seed;
    return d;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at result %0d: %s got %0h expected %0h", results_seen, what, got, want);
    fail_count++;
  endtask

  task automatic queue_req(input logic [2:0] kind, input logic [15:0] n,
                           input logic [31:0] sv, input bit drain);
    draw_req_t r;
    r.kind = kind;
    r.n = n;
    r.seed = sv;
    r.drain = drain;
    pending_reqs.push_back(r);
  endtask

  // request driver: predicts on each accepted beat, then presents the next one
  always @(posedge clk) begin : drive_requests
    draw_req_t nxt;
    draw_req_t taken;
    logic      send;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        taken.kind = req_type;
        taken.n = range_n;
        taken.seed = seed_value;
        taken.drain = 1'b0;
        expected_draws.push_back(predict_draw(taken));
        results_due <= results_due + 1;
        beats_in <= beats_in + 1;
      end
      if (!in_valid || in_ready) begin
        send = pending_reqs.size() != 0;
        if (send && pending_reqs[0].drain)
          send = (results_due == results_seen) && !(in_valid && in_ready);
        if (send && !quiet && $urandom_range(0, 99) < IDLE_PCT) send = 1'b0;
        if (send) begin
          nxt = pending_reqs.pop_front();
          req_type <= nxt.kind;
          range_n <= nxt.n;
          seed_value <= nxt.seed;
        end
        in_valid <= send;
      end
    end
  end

  // result checker and receiver stalls
  always @(posedge clk) begin : check_results
    draw_result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (expected_draws.size() == 0) begin
        report_mismatch("unexpected beat, seed_now", seed_now, '0);
      end else begin
        want = expected_draws.pop_front();
        if (draw_value !== want.draw)
          report_mismatch("draw_value", 32'(draw_value), 32'(want.draw));
        if (seed_now !== want.seed) report_mismatch("seed_now", seed_now, want.seed);
      end
    end
    if (rst) out_ready <= 1'b0;
    else out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // stimulus and end of run
  initial begin : run_test
    int          i;
    int          roll;
    logic [2:0]  kind;
    logic [15:0] n;
    logic [31:0] sv;

    // directed: edges of the range bound, loads at and above the modulus, spare kinds
    queue_req(lcgrdu_pkg::REQ_RAW, 16'd0, 32'd0, 1'b0);
    queue_req(lcgrdu_pkg::REQ_RAW, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    queue_req(lcgrdu_pkg::REQ_BIT, 16'd0, 32'd0, 1'b0);
    queue_req(lcgrdu_pkg::REQ_FRAC, 16'd0, 32'd0, 1'b0);
    queue_req(lcgrdu_pkg::REQ_RANGE, lcgrdu_pkg::LCG_ROOT, 32'd0, 1'b0);
    queue_req(lcgrdu_pkg::REQ_RANGE, 16'd1, 32'd0, 1'b0);
    queue_req(lcgrdu_pkg::REQ_RANGE, 16'd0, 32'd0, 1'b0);
    queue_req(lcgrdu_pkg::REQ_RANGE, 16'hFFFF, 32'd0, 1'b0);
    queue_req(lcgrdu_pkg::REQ_RANGE, lcgrdu_pkg::LCG_ROOT + 16'd1, 32'd0, 1'b0);
    queue_req(lcgrdu_pkg::REQ_LOAD, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    queue_req(lcgrdu_pkg::REQ_RAW, 16'd0, 32'd0, 1'b0);
    queue_req(lcgrdu_pkg::REQ_LOAD, 16'd0, 32'(lcgrdu_pkg::LCG_MOD), 1'b0);
    queue_req(lcgrdu_pkg::REQ_RANGE, lcgrdu_pkg::LCG_ROOT, 32'd0, 1'b0);
    queue_req(lcgrdu_pkg::REQ_LOAD, 16'd0, 32'(lcgrdu_pkg::LCG_MOD) - 32'd1, 1'b0);
    queue_req(lcgrdu_pkg::REQ_RANGE, lcgrdu_pkg::LCG_ROOT, 32'd0, 1'b0);
    queue_req(lcgrdu_pkg::REQ_LOAD, 16'd0, 32'h8000_0000, 1'b1);
    queue_req(lcgrdu_pkg::REQ_BIT, 16'd0, 32'd0, 1'b0);
    queue_req(lcgrdu_pkg::REQ_FRAC, 16'd0, 32'd0, 1'b0);
    queue_req(REQ_SPARE_FIRST, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    queue_req(REQ_SPARE_FIRST + 3'd1, 16'd7, 32'd1, 1'b0);
    queue_req(REQ_SPARE_LAST, 16'd0, 32'h5555_5555, 1'b0);
    queue_req(lcgrdu_pkg::REQ_LOAD, 16'hFFFF, 32'd0, 1'b0);
    queue_req(lcgrdu_pkg::REQ_RAW, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    queue_req(lcgrdu_pkg::REQ_LOAD, 16'd0, 32'(lcgrdu_pkg::LCG_HALF), 1'b0);
    queue_req(lcgrdu_pkg::REQ_BIT, 16'd0, 32'd0, 1'b0);

    // random mix, mostly draws with a fair share of reloads
    for (i = 0; i < RANDOM_REQS; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 20) kind = lcgrdu_pkg::REQ_RAW;
      else if (roll < 40) kind = lcgrdu_pkg::REQ_RANGE;
      else if (roll < 60) kind = lcgrdu_pkg::REQ_BIT;
      else if (roll < 75) kind = lcgrdu_pkg::REQ_FRAC;
      else if (roll < 94) kind = lcgrdu_pkg::REQ_LOAD;
      else kind = 3'($urandom_range(32'(REQ_SPARE_FIRST), 32'(REQ_SPARE_LAST)));
      if ($urandom_range(0, 9) == 0) n = 16'($urandom);
      else n = 16'($urandom_range(1, 32'(lcgrdu_pkg::LCG_ROOT)));
      case ($urandom_range(0, 3))
        0: sv = $urandom;
        1: sv = 32'(lcgrdu_pkg::LCG_MOD) + 32'($urandom_range(0, 16)) - 32'd8;
        2: sv = 32'($urandom_range(0, 1000));
        default: sv = 32'hFFFF_FFFF - 32'($urandom_range(0, 1000));
      endcase
      queue_req(kind, n, sv, (i == 200) || (i == 550));
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // wait for every request to go in and every result to come out
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || results_due != results_seen);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
